[design/rational_quadratic_bezier_eval_assert.svh]
`ifndef RATIONAL_QUADRATIC_BEZIER_EVAL_ASSERT_SVH
`define RATIONAL_QUADRATIC_BEZIER_EVAL_ASSERT_SVH

// same-cycle implication, checked on the rising clock edge outside reset
`define RQBE_ASSERT_IMPL(label, cond, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error("rqbe check failed");

// next-cycle implication, the consequent may carry its own delay
`define RQBE_ASSERT_NEXT(label, cond, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> prop) \
      else $error("rqbe check failed");

`endif

[design/rqbe_pkg.sv]
package rqbe_pkg;

   localparam int unsigned T_WIDTH     = 17;
   localparam int unsigned COORD_WIDTH = 32;
   // quotient bits resolved by the divide pipeline, one per stage
   localparam int unsigned QUOT_BITS   = 32;
   // register stages ahead of the divider
   localparam int unsigned PRE_STAGES  = 7;

   localparam logic [1:0] STATUS_OK         = 2'd0;
   localparam logic [1:0] STATUS_ZERO_TOTAL = 2'd1;
   localparam logic [1:0] STATUS_SATURATED  = 2'd2;

   localparam logic [COORD_WIDTH-1:0] SAT_POS = 32'h7FFF_FFFF;
   localparam logic [COORD_WIDTH-1:0] SAT_NEG = 32'h8000_0000;

   typedef struct packed {
      logic [T_WIDTH-1:0]            t_param;
      logic signed [COORD_WIDTH-1:0] weight0;
      logic signed [COORD_WIDTH-1:0] weight1;
      logic signed [COORD_WIDTH-1:0] weight2;
      logic signed [COORD_WIDTH-1:0] coord0;
      logic signed [COORD_WIDTH-1:0] coord1;
      logic signed [COORD_WIDTH-1:0] coord2;
      logic                          last_in;
   } req_type;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] point_coord;
      logic                          last_out;
      logic [1:0]                    status;
   } rsp_type;

   // per-transaction flags that ride along the pipeline
   typedef struct packed {
      logic                   last;
      logic                   bypass;
      logic [COORD_WIDTH-1:0] bypass_value;
      logic                   zero_total;
      logic                   negative;
      logic                   overflow;
   } side_type;

endpackage

[design/rational_quadratic_bezier_eval.sv]
// stages: a result is strobed once its request has passed 7 arithmetic
// stages, 32 divide stages and one output register, for every T_FRAC_BITS
// throughput: one transaction per clock cycle outside reset; each divide stage resolves one quotient bit
// reset: synchronous, clears every valid bit and holds busy high while asserted
// the receiver cannot stall, so busy is low at all times outside reset
`include "rational_quadratic_bezier_eval_assert.svh"

module rational_quadratic_bezier_eval #(
   parameter int unsigned T_FRAC_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  rqbe_pkg::req_type req_payload,
   output logic              busy,
   output logic              strobe,
   output rqbe_pkg::rsp_type rsp_payload
);

   localparam int unsigned F       = T_FRAC_BITS;
   localparam int unsigned NW      = F + 66;
   localparam int unsigned ZW      = F + 34;
   localparam int unsigned QB      = rqbe_pkg::QUOT_BITS;
   localparam int unsigned LATENCY = rqbe_pkg::PRE_STAGES + QB + 1;

   logic               accept;
   logic               bern_valid;
   rqbe_pkg::side_type bern_side;
   rqbe_pkg::req_type  bern_req;
   logic [F-1:0]       bern_b0;
   logic [F-1:0]       bern_b1;
   logic [F-1:0]       bern_b2;

   logic               div_valid [QB+1];
   rqbe_pkg::side_type div_side  [QB+1];
   logic [NW-1:0]      div_rem   [QB+1];
   logic [ZW-1:0]      div_den   [QB+1];
   logic [QB-1:0]      div_quot  [QB+1];

   rqbe_pkg::side_type fin_side;
   logic [QB-1:0]      fin_quot;

   logic               strobe_ff;
   rqbe_pkg::rsp_type  rsp_ff, rsp_in;

   assign busy   = reset;
   assign accept = start && !busy;

   rqbe_bernstein #(
      .T_FRAC_BITS(F)
   ) u_bernstein (
      .clock    (clock),
      .reset    (reset),
      .in_valid (accept),
      .in_req   (req_payload),
      .out_valid(bern_valid),
      .out_side (bern_side),
      .out_req  (bern_req),
      .out_b0   (bern_b0),
      .out_b1   (bern_b1),
      .out_b2   (bern_b2)
   );

   rqbe_sum #(
      .T_FRAC_BITS(F)
   ) u_sum (
      .clock    (clock),
      .reset    (reset),
      .in_valid (bern_valid),
      .in_side  (bern_side),
      .in_req   (bern_req),
      .in_b0    (bern_b0),
      .in_b1    (bern_b1),
      .in_b2    (bern_b2),
      .out_valid(div_valid[0]),
      .out_side (div_side[0]),
      .out_num  (div_rem[0]),
      .out_den  (div_den[0])
   );

   assign div_quot[0] = '0;

   // restoring divider, most significant quotient bit first
   for (genvar j = 0; j < QB; j++) begin : g_div
      rqbe_div_step #(
         .NW   (NW),
         .ZW   (ZW),
         .SHIFT(QB - 1 - j)
      ) u_step (
         .clock    (clock),
         .reset    (reset),
         .in_valid (div_valid[j]),
         .in_side  (div_side[j]),
         .in_rem   (div_rem[j]),
         .in_den   (div_den[j]),
         .in_quot  (div_quot[j]),
         .out_valid(div_valid[j+1]),
         .out_side (div_side[j+1]),
         .out_rem  (div_rem[j+1]),
         .out_den  (div_den[j+1]),
         .out_quot (div_quot[j+1])
      );
   end

   always_comb begin
      fin_side           = div_side[QB];
      fin_quot           = div_quot[QB];
      rsp_in.last_out    = fin_side.last;
      rsp_in.status      = rqbe_pkg::STATUS_OK;
      rsp_in.point_coord = '0;
      if (fin_side.bypass) begin
         rsp_in.point_coord = fin_side.bypass_value;
      end else if (fin_side.zero_total) begin
         rsp_in.status = rqbe_pkg::STATUS_ZERO_TOTAL;
      end else if (fin_side.negative) begin
         if (fin_side.overflow || (fin_quot > rqbe_pkg::SAT_NEG)) begin
            rsp_in.point_coord = rqbe_pkg::SAT_NEG;
            rsp_in.status      = rqbe_pkg::STATUS_SATURATED;
         end else begin
            rsp_in.point_coord = -fin_quot;
         end
      end else begin
         if (fin_side.overflow || fin_quot[QB-1]) begin
            rsp_in.point_coord = rqbe_pkg::SAT_POS;
            rsp_in.status      = rqbe_pkg::STATUS_SATURATED;
         end else begin
            rsp_in.point_coord = fin_quot;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= div_valid[QB];
      end
      rsp_ff <= rsp_in;
   end

   assign strobe      = strobe_ff;
   assign rsp_payload = rsp_ff;

   `RQBE_ASSERT_NEXT(a_fixed_latency, accept, ##(LATENCY - 1) strobe)
   `RQBE_ASSERT_IMPL(a_no_spurious_result, strobe, $past(accept, LATENCY))
   `RQBE_ASSERT_IMPL(a_remainder_below_divisor,
      div_valid[QB] && !fin_side.bypass && !fin_side.zero_total && !fin_side.overflow,
      div_rem[QB] < NW'(div_den[QB]))
   `RQBE_ASSERT_IMPL(a_saturated_value,
      strobe && (rsp_payload.status == rqbe_pkg::STATUS_SATURATED),
      (rsp_payload.point_coord == rqbe_pkg::SAT_POS) ||
      (rsp_payload.point_coord == rqbe_pkg::SAT_NEG))

endmodule

[design/rqbe_bernstein.sv]
module rqbe_bernstein #(
   parameter int unsigned T_FRAC_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  rqbe_pkg::req_type      in_req,
   output logic                   out_valid,
   output rqbe_pkg::side_type     out_side,
   output rqbe_pkg::req_type      out_req,
   output logic [T_FRAC_BITS-1:0] out_b0,
   output logic [T_FRAC_BITS-1:0] out_b1,
   output logic [T_FRAC_BITS-1:0] out_b2
);

   localparam int unsigned F  = T_FRAC_BITS;
   localparam int unsigned TB = F + 1;
   localparam int unsigned PB = 2 * TB;

   logic [TB-1:0]  t_ext;
   logic [TB-1:0]  s_val;
   logic [PB-1:0]  ss_prod;
   logic [PB-1:0]  st_prod;
   logic [PB-1:0]  tt_prod;
   logic           t_zero;
   logic           t_full;

   logic                 valid_ff;
   rqbe_pkg::side_type   side_ff, side_in;
   rqbe_pkg::req_type    req_ff;
   logic [F-1:0]         b0_ff, b0_in;
   logic [F-1:0]         b1_ff, b1_in;
   logic [F-1:0]         b2_ff, b2_in;

   always_comb begin
      t_zero  = (in_req.t_param == '0);
      t_full  = (32'(in_req.t_param) >= (32'(1) << F));
      // only meaningful below one, where t fits in TB bits
      t_ext   = TB'(in_req.t_param);
      s_val   = (TB'(1) << F) - t_ext;
      ss_prod = PB'(s_val) * PB'(s_val);
      st_prod = PB'(s_val) * PB'(t_ext);
      tt_prod = PB'(t_ext) * PB'(t_ext);
      b0_in   = ss_prod[F +: F];
      // 2*s*t >> F is s*t >> (F-1)
      b1_in   = st_prod[F-1 +: F];
      b2_in   = tt_prod[F +: F];

      side_in              = '0;
      side_in.last         = in_req.last_in;
      side_in.bypass       = t_zero || t_full;
      side_in.bypass_value = t_zero ? in_req.coord0 : in_req.coord2;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      side_ff <= side_in;
      req_ff  <= in_req;
      b0_ff   <= b0_in;
      b1_ff   <= b1_in;
      b2_ff   <= b2_in;
   end

   assign out_valid = valid_ff;
   assign out_side  = side_ff;
   assign out_req   = req_ff;
   assign out_b0    = b0_ff;
   assign out_b1    = b1_ff;
   assign out_b2    = b2_ff;

endmodule

[design/rqbe_sum.sv]
module rqbe_sum #(
   parameter int unsigned T_FRAC_BITS = 16,
   localparam int unsigned NW = T_FRAC_BITS + 66,
   localparam int unsigned ZW = T_FRAC_BITS + 34
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  rqbe_pkg::side_type     in_side,
   input  rqbe_pkg::req_type      in_req,
   input  logic [T_FRAC_BITS-1:0] in_b0,
   input  logic [T_FRAC_BITS-1:0] in_b1,
   input  logic [T_FRAC_BITS-1:0] in_b2,
   output logic                   out_valid,
   output rqbe_pkg::side_type     out_side,
   output logic [NW-1:0]          out_num,
   output logic [ZW-1:0]          out_den
);

   localparam int unsigned F  = T_FRAC_BITS;
   localparam int unsigned AW = F + 32;
   localparam int unsigned PW = AW + 32;
   localparam int unsigned QB = rqbe_pkg::QUOT_BITS;

   logic signed [31:0] w_arr [3];
   logic [F-1:0]       b_arr [3];

   // weighted basis terms
   logic signed [AW:0]   wb_prod [3];
   logic signed [AW-1:0] s2_a_ff [3], s2_a_in [3];
   logic signed [31:0]   s2_c_ff [3];
   rqbe_pkg::side_type   s2_side_ff;
   logic                 s2_valid_ff;

   // weight total and split partial products
   logic signed [ZW-1:0]   s3_z_in;
   logic signed [64:0]     s3_pl_in [3];
   logic signed [F+31:0]   s3_ph_in [3];
   logic signed [ZW-1:0]   s3_z_ff;
   logic signed [64:0]     s3_pl_ff [3];
   logic signed [F+31:0]   s3_ph_ff [3];
   rqbe_pkg::side_type     s3_side_ff;
   logic                   s3_valid_ff;

   // full weighted coordinate products
   logic signed [PW-1:0] s4_p_ff [3], s4_p_in [3];
   logic signed [ZW-1:0] s4_z_ff;
   rqbe_pkg::side_type   s4_side_ff;
   logic                 s4_valid_ff;

   // numerator
   logic signed [NW-1:0] s5_n_ff, s5_n_in;
   logic signed [ZW-1:0] s5_z_ff;
   rqbe_pkg::side_type   s5_side_ff;
   logic                 s5_valid_ff;

   // magnitudes and signs
   logic                 n_neg;
   logic                 z_neg;
   logic [NW-1:0]        s6_num_ff, s6_num_in;
   logic [ZW-1:0]        s6_den_ff, s6_den_in;
   rqbe_pkg::side_type   s6_side_ff, s6_side_in;
   logic                 s6_valid_ff;

   // quotient range check
   logic [NW-1:0]        s7_num_ff;
   logic [ZW-1:0]        s7_den_ff;
   rqbe_pkg::side_type   s7_side_ff, s7_side_in;
   logic                 s7_valid_ff;

   always_comb begin
      w_arr[0] = in_req.weight0;
      w_arr[1] = in_req.weight1;
      w_arr[2] = in_req.weight2;
      b_arr[0] = in_b0;
      b_arr[1] = in_b1;
      b_arr[2] = in_b2;
      for (int k = 0; k < 3; k++) begin
         wb_prod[k] = $signed(w_arr[k]) * $signed({1'b0, b_arr[k]});
         s2_a_in[k] = wb_prod[k][AW-1:0];
      end
   end

   always_comb begin
      s3_z_in = ZW'(s2_a_ff[0]) + ZW'(s2_a_ff[1]) + ZW'(s2_a_ff[2]);
      for (int k = 0; k < 3; k++) begin
         s3_pl_in[k] = $signed({1'b0, s2_a_ff[k][31:0]}) * s2_c_ff[k];
         s3_ph_in[k] = $signed(s2_a_ff[k][AW-1:32]) * s2_c_ff[k];
      end
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         s4_p_in[k] = (PW'(s3_ph_ff[k]) <<< 32) + PW'(s3_pl_ff[k]);
      end
   end

   assign s5_n_in = NW'(s4_p_ff[0]) + NW'(s4_p_ff[1]) + NW'(s4_p_ff[2]);

   always_comb begin
      n_neg                 = s5_n_ff[NW-1];
      z_neg                 = s5_z_ff[ZW-1];
      s6_num_in             = n_neg ? NW'(-s5_n_ff) : NW'(s5_n_ff);
      s6_den_in             = z_neg ? ZW'(-s5_z_ff) : ZW'(s5_z_ff);
      s6_side_in            = s5_side_ff;
      s6_side_in.zero_total = (s5_z_ff == '0);
      s6_side_in.negative   = n_neg ^ z_neg;
   end

   always_comb begin
      s7_side_in          = s6_side_ff;
      // quotient needs more than QB bits
      s7_side_in.overflow = (s6_num_ff >= (NW'(s6_den_ff) << QB));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
         s6_valid_ff <= 1'b0;
         s7_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= in_valid;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         s5_valid_ff <= s4_valid_ff;
         s6_valid_ff <= s5_valid_ff;
         s7_valid_ff <= s6_valid_ff;
      end
      s2_a_ff    <= s2_a_in;
      s2_c_ff[0] <= in_req.coord0;
      s2_c_ff[1] <= in_req.coord1;
      s2_c_ff[2] <= in_req.coord2;
      s2_side_ff <= in_side;
      s3_z_ff    <= s3_z_in;
      s3_pl_ff   <= s3_pl_in;
      s3_ph_ff   <= s3_ph_in;
      s3_side_ff <= s2_side_ff;
      s4_p_ff    <= s4_p_in;
      s4_z_ff    <= s3_z_ff;
      s4_side_ff <= s3_side_ff;
      s5_n_ff    <= s5_n_in;
      s5_z_ff    <= s4_z_ff;
      s5_side_ff <= s4_side_ff;
      s6_num_ff  <= s6_num_in;
      s6_den_ff  <= s6_den_in;
      s6_side_ff <= s6_side_in;
      s7_num_ff  <= s6_num_ff;
      s7_den_ff  <= s6_den_ff;
      s7_side_ff <= s7_side_in;
   end

   assign out_valid = s7_valid_ff;
   assign out_side  = s7_side_ff;
   assign out_num   = s7_num_ff;
   assign out_den   = s7_den_ff;

endmodule

[design/rqbe_div_step.sv]
module rqbe_div_step #(
   parameter int unsigned NW    = 82,
   parameter int unsigned ZW    = 50,
   parameter int unsigned SHIFT = 0
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 in_valid,
   input  rqbe_pkg::side_type                   in_side,
   input  logic [NW-1:0]                        in_rem,
   input  logic [ZW-1:0]                        in_den,
   input  logic [rqbe_pkg::QUOT_BITS-1:0]       in_quot,
   output logic                                 out_valid,
   output rqbe_pkg::side_type                   out_side,
   output logic [NW-1:0]                        out_rem,
   output logic [ZW-1:0]                        out_den,
   output logic [rqbe_pkg::QUOT_BITS-1:0]       out_quot
);

   localparam int unsigned QB = rqbe_pkg::QUOT_BITS;

   logic [NW-1:0] trial;
   logic [NW:0]   diff;
   logic          fits;

   logic               valid_ff;
   rqbe_pkg::side_type side_ff;
   logic [NW-1:0]      rem_ff, rem_in;
   logic [ZW-1:0]      den_ff;
   logic [QB-1:0]      quot_ff, quot_in;

   always_comb begin
      trial   = NW'(in_den) << SHIFT;
      diff    = {1'b0, in_rem} - {1'b0, trial};
      fits    = !diff[NW];
      rem_in  = fits ? diff[NW-1:0] : in_rem;
      quot_in = fits ? (in_quot | (QB'(1) << SHIFT)) : in_quot;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      side_ff <= in_side;
      rem_ff  <= rem_in;
      den_ff  <= in_den;
      quot_ff <= quot_in;
   end

   assign out_valid = valid_ff;
   assign out_side  = side_ff;
   assign out_rem   = rem_ff;
   assign out_den   = den_ff;
   assign out_quot  = quot_ff;

endmodule
